// ===== hw/rtl/cdau_pkg.sv =====
package cdau_pkg;

    localparam logic        ACT_LOAD  = 1'b0;
    localparam logic        ACT_ADV   = 1'b1;
    localparam logic [3:0]  M_JAN     = 4'd1;
    localparam logic [3:0]  M_FEB     = 4'd2;
    localparam logic [3:0]  M_DEC     = 4'd12;
    localparam logic [8:0]  Y400_TOP  = 9'd399;
    localparam logic [8:0]  Y100      = 9'd100;
    localparam logic [8:0]  Y200      = 9'd200;
    localparam logic [8:0]  Y300      = 9'd300;
    // ceil(2^35 / 25): exact x / 25 for any 32-bit x after >> 35
    localparam logic [31:0] DIV25_MUL = 32'h51EB851F;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_LFIX,
        S_ADV,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic take_load;
        logic take_adv;
        logic mod_step;
        logic load_fix;
        logic adv_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic adv_done;
        logic out_free;
    } t_sts;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            M_FEB:                                       n = lp ? 5'd29 : 5'd28;
            default:                                     n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/cdau_ctrl.sv =====
module cdau_ctrl
    import cdau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_action,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_action == ACT_LOAD) ? S_MOD : S_ADV;
                end
            end
            S_MOD: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_LFIX;
                end
            end
            S_LFIX: n_state = S_PUSH;
            S_ADV: begin
                if (i_sts.adv_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.take_load  = accept && (i_action == ACT_LOAD);
                o_cmd.take_adv   = accept && (i_action == ACT_ADV);
            end
            S_MOD:   o_cmd.mod_step = 1'b1;
            S_LFIX:  o_cmd.load_fix = 1'b1;
            S_ADV:   o_cmd.adv_step = 1'b1;
            S_PUSH:  o_cmd.out_load = i_sts.out_free;
            default: o_ready = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/cdau_dp.sv =====
module cdau_dp
    import cdau_pkg::*;
#(
    parameter int YEAR_BITS    = 16,
    parameter int ADVANCE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [4:0]              i_day,
    input  logic [3:0]              i_month,
    input  logic [YEAR_BITS-1:0]    i_year,
    input  logic [ADVANCE_BITS-1:0] i_adv,
    input  logic                    i_out_ready,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    output logic [4:0]              o_day,
    output logic [3:0]              o_month,
    output logic [YEAR_BITS-1:0]    o_year,
    output logic                    o_leap,
    output logic                    o_unset,
    output logic                    o_ovf
);

    localparam int DW = ADVANCE_BITS + 1;

    logic [4:0]           r_day;
    logic [3:0]           r_month;
    logic [YEAR_BITS-1:0] r_year;
    logic [8:0]           r_y400;
    logic [DW-1:0]        r_d;
    logic                 r_mod_ph;
    logic [23:0]          r_q;
    logic                 r_ovf;
    logic                 r_out_valid;

    logic                 leap;
    logic [4:0]           len;
    logic                 unset;
    logic                 month_ok;
    logic                 step_needed;
    logic [31:0]          year32;
    logic [58:0]          q_prod;
    logic [31:0]          q_x400;
    logic [31:0]          y_rem;

    // year mod 400 tracked alongside the year; leap needs no divider
    assign leap     = (r_year[1:0] == 2'b00) &&
                      (r_y400 != Y100) && (r_y400 != Y200) && (r_y400 != Y300);
    assign len      = month_len(r_month, leap);
    assign unset    = (r_day == 5'd0) && (r_month == 4'd0) && (r_year == '0);
    assign month_ok = (r_month >= M_JAN) && (r_month <= M_DEC);
    assign step_needed = !unset && month_ok && (r_d > DW'(len));

    // load: q = (year >> 4) / 25 by reciprocal multiply, then year - 400 * q
    assign year32 = 32'(r_year);
    assign q_prod = 59'(year32[31:4]) * 59'(DIV25_MUL);
    assign q_x400 = {r_q, 8'd0} + {1'b0, r_q, 7'd0} + {4'd0, r_q, 4'd0};
    assign y_rem  = year32 - q_x400;

    assign o_sts.cnt_zero = !r_mod_ph;
    assign o_sts.adv_done = !step_needed;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= '0;
            r_month <= '0;
            r_year  <= '0;
            r_y400  <= '0;
        end else if (i_cmd.take_load) begin
            r_year  <= i_year;
            r_month <= ((i_month < M_JAN) || (i_month > M_DEC)) ? M_JAN : i_month;
            r_day   <= i_day;
            r_y400  <= '0;
        end else if (i_cmd.mod_step) begin
            if (!r_mod_ph) begin
                r_y400 <= y_rem[8:0];
            end
        end else if (i_cmd.load_fix) begin
            if (r_day > len) begin
                r_day <= 5'd1;
            end
        end else if (i_cmd.adv_step) begin
            if (step_needed) begin
                if (r_month == M_DEC) begin
                    r_month <= M_JAN;
                    if (r_year == '1) begin
                        r_year <= '0;
                        r_y400 <= '0;
                    end else begin
                        r_year <= r_year + YEAR_BITS'(1);
                        r_y400 <= (r_y400 == Y400_TOP) ? 9'd0 : r_y400 + 9'd1;
                    end
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else if (!unset && month_ok) begin
                r_day <= r_d[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_load) begin
            r_mod_ph <= 1'b1;
            r_ovf    <= 1'b0;
        end else if (i_cmd.take_adv) begin
            r_d   <= DW'(r_day) + DW'(i_adv);
            r_ovf <= 1'b0;
        end else if (i_cmd.mod_step) begin
            r_mod_ph <= 1'b0;
            if (r_mod_ph) begin
                r_q <= q_prod[58:35];
            end
        end else if (i_cmd.adv_step && step_needed) begin
            r_d <= r_d - DW'(len);
            if ((r_month == M_DEC) && (r_year == '1)) begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_day   <= r_day;
            o_month <= r_month;
            o_year  <= r_year;
            o_leap  <= leap;
            o_unset <= unset;
            o_ovf   <= r_ovf;
        end
    end

endmodule

// ===== hw/rtl/calendar_date_advance_unit.sv =====
// Load: mod 400 (quotient, then remainder), day fix, then push to o_m_axis_tvalid.
// Advance: months crossed one per cycle until the days fit the month, then push.
// Throughput: one request at a time; next request taken once the result sits in the
// output register, even while it waits for i_m_axis_tready.
// Reset: i_rst_n synchronous active low; clears the date to the unset date 0/0/0.
module calendar_date_advance_unit
    import cdau_pkg::*;
#(
    parameter int YEAR_BITS    = 16,
    parameter int ADVANCE_BITS = 16,
    localparam int IN_W        = ((9 + YEAR_BITS + ADVANCE_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((9 + YEAR_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // day[4:0], month[8:5], year, advance_days, zero pad
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    // action
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // day_out[4:0], month_out[8:5], year_out, zero pad
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    // leap, is_unset, year_overflow
    output logic [2:0]            o_m_axis_tuser
);

    t_cmd                 cmd;
    t_sts                 sts;
    logic [4:0]           out_day;
    logic [3:0]           out_month;
    logic [YEAR_BITS-1:0] out_year;
    logic                 out_leap;
    logic                 out_unset;
    logic                 out_ovf;

    cdau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_action (i_s_axis_tuser),
        .i_sts    (sts),
        .o_ready  (o_s_axis_tready),
        .o_cmd    (cmd)
    );

    cdau_dp #(
        .YEAR_BITS    (YEAR_BITS),
        .ADVANCE_BITS (ADVANCE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_day       (i_s_axis_tdata[4:0]),
        .i_month     (i_s_axis_tdata[8:5]),
        .i_year      (i_s_axis_tdata[9 +: YEAR_BITS]),
        .i_adv       (i_s_axis_tdata[9 + YEAR_BITS +: ADVANCE_BITS]),
        .i_out_ready (i_m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_day       (out_day),
        .o_month     (out_month),
        .o_year      (out_year),
        .o_leap      (out_leap),
        .o_unset     (out_unset),
        .o_ovf       (out_ovf)
    );

    assign o_m_axis_tdata = OUT_W'({out_year, out_month, out_day});
    assign o_m_axis_tuser = {out_ovf, out_unset, out_leap};

endmodule

// ===== hw/rtl/cdau_checker.sv =====
module cdau_checker #(
    parameter int YEAR_BITS = 16,
    parameter int OUT_W     = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic [2:0]       o_m_axis_tuser
);

    logic [4:0] day;
    logic [3:0] month;
    logic [1:0] year_lo;

    assign day     = o_m_axis_tdata[4:0];
    assign month   = o_m_axis_tdata[8:5];
    assign year_lo = o_m_axis_tdata[10:9];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) &&
        $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_unset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
        (day == 5'd0) && (month == 4'd0) && (o_m_axis_tdata[9 +: YEAR_BITS] == '0))
        else $error("unset flag with nonzero date");

    a_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> (month >= 4'd1) && (month <= 4'd12))
        else $error("month out of range");

    a_leap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> (year_lo == 2'b00))
        else $error("leap flag on year not divisible by four");

endmodule

bind calendar_date_advance_unit cdau_checker #(
    .YEAR_BITS (YEAR_BITS),
    .OUT_W     (OUT_W)
) u_cdau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
